/* rtl/hcrs_pkg.sv */
// Shared types, constants and helpers for the clipped-range histogram statistics block.
// Used by histogram_clipped_range_stats; depends on nothing else.
package hcrs_pkg;

    // Histogram geometry and field widths
    localparam int HIST_BINS  = 16384;
    localparam int BIN_W      = $clog2(HIST_BINS);
    localparam int MAX_PIXELS = 1048576;
    localparam int LEVEL_W    = 14;
    localparam int CNT_W      = 21;
    localparam int CLIP_W     = 21;
    localparam int SUM_W      = 34;

    // Divider for the rounded mean: numerator is 2*sum + count
    localparam int REM_W      = SUM_W + 1;
    localparam int DIV_STEPS  = LEVEL_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_CLIP_LO = 1'b0;
    localparam logic REG_CLIP_HI = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BIN,
        ST_SCAN,
        ST_SCAN_END,
        ST_DIV,
        ST_DONE
    } t_state;

    // Control of the single-port histogram memory
    typedef struct packed {
        logic             rd_en;
        logic             wr_en;
        logic [BIN_W-1:0] addr;
        logic [CNT_W-1:0] wdata;
    } t_mem_ctrl;

    // Levels beyond the last bin fall into the last bin.
    function automatic logic [BIN_W-1:0] sat_level(input logic [LEVEL_W-1:0] lvl);
        logic [BIN_W-1:0] res;
        if (32'(lvl) >= HIST_BINS) begin
            res = BIN_W'(HIST_BINS - 1);
        end else begin
            res = BIN_W'(lvl);
        end
        return res;
    endfunction

endpackage

/* rtl/histogram_clipped_range_stats.sv */
// Top level of the clipped-range histogram statistics block.
// Depends on hcrs_pkg for constants, the state type and the memory control struct.
//
// Pixel levels are binned into a 16384-entry single-port histogram memory. A pixel
// request reads its bin in the accept cycle and writes it back incremented in the
// next, so the input is stalled during each write-back. The request that carries
// frame_last closes the frame: one sweep over the memory finds the lowest and
// highest occupied bins and both clipped levels while clearing every bin, then a
// restoring divider computes the rounded mean, and ST_DONE hands the result to the
// output register once that register is free. The input is stalled through all of
// that. After reset the block clears every bin of the memory before it takes the
// first pixel; configuration writes are taken at any time.
// A finished result waits in the output register while the next frame streams in.
module histogram_clipped_range_stats (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Pixel requests
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [hcrs_pkg::LEVEL_W-1:0]      i_pixel_level,
    input  logic                              i_frame_last,
    // Frame results
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [hcrs_pkg::LEVEL_W-1:0]      o_min_level,
    output logic [hcrs_pkg::LEVEL_W-1:0]      o_max_level,
    output logic [hcrs_pkg::LEVEL_W-1:0]      o_min_clipped,
    output logic [hcrs_pkg::LEVEL_W-1:0]      o_max_clipped,
    output logic [hcrs_pkg::LEVEL_W-1:0]      o_average,
    // Configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hcrs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hcrs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hcrs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import hcrs_pkg::*;

    t_state            r_state;
    t_state            n_state;
    t_mem_ctrl         mem_c;

    logic [CNT_W-1:0]  r_bin_mem [HIST_BINS];
    logic [CNT_W-1:0]  r_rd_data;

    logic [CLIP_W-1:0] r_clip_lo;
    logic [CLIP_W-1:0] r_clip_hi;

    logic [BIN_W-1:0]  r_lvl;
    logic              r_last;
    logic [SUM_W-1:0]  r_sum;
    logic [CNT_W-1:0]  r_pix_cnt;

    logic [BIN_W-1:0]  r_addr;
    logic              r_pvld;
    logic [BIN_W-1:0]  r_paddr;
    logic [CNT_W:0]    r_acc;
    logic              r_seen;
    logic              r_clo_hit;
    logic [BIN_W-1:0]  r_lo;
    logic [BIN_W-1:0]  r_hi;
    logic [BIN_W-1:0]  r_clo;
    logic [BIN_W-1:0]  r_chi;

    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_dsh;
    logic [STEP_W-1:0] r_step;
    logic [LEVEL_W-1:0] r_quot;

    logic              r_out_valid;
    logic [LEVEL_W-1:0] r_out_min;
    logic [LEVEL_W-1:0] r_out_max;
    logic [LEVEL_W-1:0] r_out_clo;
    logic [LEVEL_W-1:0] r_out_chi;
    logic [LEVEL_W-1:0] r_out_avg;

    logic              in_accept;
    logic              cfg_write;
    logic              addr_last;
    logic              pix_room;
    logic              out_free;
    logic              out_load;
    logic              bin_occ;
    logic [CNT_W:0]    prefix_incl;
    logic [CNT_W:0]    tail_need;
    logic              rem_ge;
    logic [BIN_W-1:0]  fin_clo;
    logic [BIN_W-1:0]  fin_chi;
    logic              frame_empty;

    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign addr_last = (r_addr == BIN_W'(HIST_BINS - 1));
    assign pix_room  = (32'(r_pix_cnt) < MAX_PIXELS);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign out_load  = (r_state == ST_DONE) && out_free;

    // Configuration registers and read-back.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_lo <= '0;
            r_clip_hi <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_CLIP_LO) begin
                r_clip_lo <= pwdata[CLIP_W-1:0];
            end else begin
                r_clip_hi <= pwdata[CLIP_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CLIP_LO) ? APB_DATA_W'(r_clip_lo)
                                              : APB_DATA_W'(r_clip_hi);

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_BIN;
            end
            ST_BIN: begin
                n_state = r_last ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (addr_last) n_state = ST_SCAN_END;
            end
            ST_SCAN_END: begin
                n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_step == '0) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Memory control and input stall for each state.
    always_comb begin
        mem_c      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                mem_c.wr_en = 1'b1;
                mem_c.addr  = r_addr;
            end
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                mem_c.rd_en = i_in_valid;
                mem_c.addr  = sat_level(i_pixel_level);
            end
            ST_BIN: begin
                mem_c.wr_en = pix_room;
                mem_c.addr  = r_lvl;
                mem_c.wdata = r_rd_data + CNT_W'(1);
            end
            ST_SCAN: begin
                mem_c.rd_en = 1'b1;
                mem_c.wr_en = 1'b1;
                mem_c.addr  = r_addr;
            end
            ST_SCAN_END, ST_DIV, ST_DONE: begin
                mem_c = '0;
            end
            default: begin
                mem_c = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Histogram memory: read-first, so a scan read sees the count it clears.
    always_ff @(posedge i_clk) begin
        if (mem_c.rd_en) begin
            r_rd_data <= r_bin_mem[mem_c.addr];
        end
        if (mem_c.wr_en) begin
            r_bin_mem[mem_c.addr] <= mem_c.wdata;
        end
    end

    // Sweep address for the clearing pass and the end-of-frame scan.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (r_state == ST_CLEAR || r_state == ST_SCAN) begin
            r_addr <= addr_last ? '0 : r_addr + BIN_W'(1);
        end
    end

    // Latch the accepted pixel.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_lvl  <= sat_level(i_pixel_level);
            r_last <= i_frame_last;
        end
    end

    // Running sum and pixel count of the frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum     <= '0;
            r_pix_cnt <= '0;
        end else if (r_state == ST_BIN && pix_room) begin
            r_sum     <= r_sum + SUM_W'(r_lvl);
            r_pix_cnt <= r_pix_cnt + CNT_W'(1);
        end else if (out_load) begin
            r_sum     <= '0;
            r_pix_cnt <= '0;
        end
    end

    // Scan of one bin: data arrives in the cycle after its address.
    assign bin_occ     = (r_rd_data != '0);
    assign prefix_incl = r_acc + (CNT_W+1)'(r_rd_data);
    assign tail_need   = r_acc + (CNT_W+1)'(r_clip_hi);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= (r_state == ST_SCAN);
        end
        r_paddr <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_BIN && r_last) begin
            r_acc     <= '0;
            r_seen    <= 1'b0;
            r_clo_hit <= 1'b0;
            r_lo      <= '0;
            r_hi      <= '0;
            r_clo     <= '0;
            r_chi     <= '0;
        end else if (r_pvld) begin
            r_acc <= prefix_incl;
            if (bin_occ) begin
                if (!r_seen) begin
                    r_lo   <= r_paddr;
                    r_seen <= 1'b1;
                end
                r_hi <= r_paddr;
                // First occupied bin whose running count reaches the low clip.
                if (!r_clo_hit && prefix_incl >= (CNT_W+1)'(r_clip_lo)) begin
                    r_clo     <= r_paddr;
                    r_clo_hit <= 1'b1;
                end
                // Last occupied bin with at least the high clip at or above it.
                if (tail_need <= (CNT_W+1)'(r_pix_cnt)) begin
                    r_chi <= r_paddr;
                end
            end
        end
    end

    // Restoring divider: (2*sum + count) / (2*count), one quotient bit a cycle.
    assign rem_ge = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN_END) begin
            r_rem  <= REM_W'({r_sum, 1'b0}) + REM_W'(r_pix_cnt);
            r_dsh  <= REM_W'({r_pix_cnt, 1'b0}) << (DIV_STEPS - 1);
            r_step <= STEP_W'(DIV_STEPS - 1);
            r_quot <= '0;
        end else if (r_state == ST_DIV) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - STEP_W'(1);
            r_quot <= {r_quot[LEVEL_W-2:0], rem_ge};
        end
    end

    // Clip values beyond the frame saturate at the opposite extreme.
    assign frame_empty = (r_pix_cnt == '0);
    assign fin_clo     = (r_clip_lo > r_pix_cnt) ? r_hi : r_clo;
    assign fin_chi     = (r_clip_hi > r_pix_cnt) ? r_lo : r_chi;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            if (frame_empty) begin
                r_out_min <= '0;
                r_out_max <= '0;
                r_out_clo <= '0;
                r_out_chi <= '0;
                r_out_avg <= '0;
            end else begin
                r_out_min <= LEVEL_W'(r_lo);
                r_out_max <= LEVEL_W'(r_hi);
                r_out_clo <= LEVEL_W'(fin_clo);
                r_out_chi <= LEVEL_W'(fin_chi);
                r_out_avg <= r_quot;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_min_level   = r_out_min;
    assign o_max_level   = r_out_max;
    assign o_min_clipped = r_out_clo;
    assign o_max_clipped = r_out_chi;
    assign o_average     = r_out_avg;

endmodule
